// ===== sv/atbp_pkg.sv =====
// ----------------------------------------------------------------------------
// atbp_pkg
// Shared types, byte codes, color tables and helpers for the terminal parser.
// ----------------------------------------------------------------------------
package atbp_pkg;

  localparam int ROW_W      = 6;
  localparam int COL_W      = 7;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int NUM_CELLS  = 1 << ADDR_W;
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 128;
  localparam int MAX_PARAMS = 16;
  localparam int PIDX_W     = 4;
  localparam int PCNT_W     = 5;
  localparam int PVAL_W     = 16;
  localparam int PENT_W     = PVAL_W + 1;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  localparam logic [7:0] BYTE_BEL    = 8'h07;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_BANG   = 8'h21;
  localparam logic [7:0] BYTE_LPAREN = 8'h28;
  localparam logic [7:0] BYTE_RPAREN = 8'h29;
  localparam logic [7:0] DIGIT_0     = 8'h30;
  localparam logic [7:0] DIGIT_9     = 8'h39;
  localparam logic [7:0] BYTE_SEMI   = 8'h3B;
  localparam logic [7:0] BYTE_GT     = 8'h3E;
  localparam logic [7:0] BYTE_QMARK  = 8'h3F;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_BSLASH = 8'h5C;
  localparam logic [7:0] BYTE_RBRACK = 8'h5D;

  localparam logic [7:0] ESC_RESET   = 8'h63;
  localparam logic [7:0] ESC_INDEX   = 8'h44;
  localparam logic [7:0] ESC_NEWLINE = 8'h45;
  localparam logic [7:0] ESC_REVIDX  = 8'h4D;

  localparam logic [7:0] CSI_UP      = 8'h41;
  localparam logic [7:0] CSI_DOWN    = 8'h42;
  localparam logic [7:0] CSI_FWD     = 8'h43;
  localparam logic [7:0] CSI_BACK    = 8'h44;
  localparam logic [7:0] CSI_POS     = 8'h48;
  localparam logic [7:0] CSI_POS_F   = 8'h66;
  localparam logic [7:0] CSI_ERASE   = 8'h4A;
  localparam logic [7:0] CSI_ERASE_L = 8'h4B;
  localparam logic [7:0] CSI_SGR     = 8'h6D;
  localparam logic [7:0] CSI_SCROLL  = 8'h53;

  localparam logic [15:0] SGR_RESET     = 16'd0;
  localparam logic [15:0] SGR_BOLD      = 16'd1;
  localparam logic [15:0] SGR_ITALIC    = 16'd3;
  localparam logic [15:0] SGR_UNDER     = 16'd4;
  localparam logic [15:0] SGR_REVERSE   = 16'd7;
  localparam logic [15:0] SGR_NO_BOLD   = 16'd22;
  localparam logic [15:0] SGR_NO_ITALIC = 16'd23;
  localparam logic [15:0] SGR_NO_UNDER  = 16'd24;
  localparam logic [15:0] SGR_NO_REV    = 16'd27;
  localparam logic [15:0] SGR_FG_EXT    = 16'd38;
  localparam logic [15:0] SGR_FG_DEF    = 16'd39;
  localparam logic [15:0] SGR_BG_EXT    = 16'd48;
  localparam logic [15:0] SGR_BG_DEF    = 16'd49;
  localparam logic [15:0] SGR_FG_LO     = 16'd30;
  localparam logic [15:0] SGR_FG_HI     = 16'd37;
  localparam logic [15:0] SGR_BG_LO     = 16'd40;
  localparam logic [15:0] SGR_BG_HI     = 16'd47;
  localparam logic [15:0] SGR_FGB_LO    = 16'd90;
  localparam logic [15:0] SGR_FGB_HI    = 16'd97;
  localparam logic [15:0] SGR_BGB_LO    = 16'd100;
  localparam logic [15:0] SGR_BGB_HI    = 16'd107;
  localparam logic [16:0] EXT_RGB       = 17'd2;
  localparam logic [16:0] EXT_INDEX     = 17'd5;

  localparam logic [3:0] FL_BOLD    = 4'b0001;
  localparam logic [3:0] FL_ITALIC  = 4'b0010;
  localparam logic [3:0] FL_UNDER   = 4'b0100;
  localparam logic [3:0] FL_REVERSE = 4'b1000;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t       fg;
    rgb_t       bg;
    logic [3:0] flags;
  } pen_t;

  typedef struct packed {
    logic [7:0] ch;
    pen_t       pen;
  } cell_t;

  localparam rgb_t  DEF_FG     = '{r: 8'd200, g: 8'd200, b: 8'd200};
  localparam rgb_t  DEF_BG     = '{r: 8'd10, g: 8'd10, b: 8'd18};
  localparam pen_t  DEF_PEN    = '{fg: DEF_FG, bg: DEF_BG, flags: 4'd0};
  localparam cell_t BLANK_CELL = '{ch: BYTE_SPACE, pen: DEF_PEN};

  typedef struct packed {
    logic                 mode;
    logic [7:0]           in_byte;
    logic [ROW_W-1:0]     read_row;
    logic [COL_W-1:0]     read_col;
  } in_word_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       fg_red;
    logic [7:0]       fg_green;
    logic [7:0]       fg_blue;
    logic [7:0]       bg_red;
    logic [7:0]       bg_green;
    logic [7:0]       bg_blue;
    logic [3:0]       cell_flags;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
  } out_word_t;

  typedef struct packed {
    logic       digit;
    logic [3:0] digit_val;
    logic       push;
    logic       leader;
    logic       clear_num;
    logic       clear_count;
  } plex_t;

  typedef struct packed {
    logic [PCNT_W-1:0] count;
    logic [PENT_W-1:0] rdata;
    logic              pending;
  } pinfo_t;

  function automatic logic [6:0] clamp_rows(input logic [6:0] r);
    if (r == 7'd0) return 7'd1;
    if (r > 7'(MAX_ROWS)) return 7'(MAX_ROWS);
    return r;
  endfunction

  function automatic logic [7:0] clamp_cols(input logic [7:0] c);
    if (c == 8'd0) return 8'd1;
    if (c > 8'(MAX_COLS)) return 8'(MAX_COLS);
    return c;
  endfunction

  function automatic rgb_t base_color(input logic [3:0] idx);
    rgb_t c;
    case (idx)
      4'd0:    c = '{8'd10, 8'd10, 8'd18};
      4'd1:    c = '{8'd200, 8'd50, 8'd50};
      4'd2:    c = '{8'd50, 8'd200, 8'd50};
      4'd3:    c = '{8'd200, 8'd200, 8'd50};
      4'd4:    c = '{8'd50, 8'd50, 8'd200};
      4'd5:    c = '{8'd200, 8'd50, 8'd200};
      4'd6:    c = '{8'd50, 8'd200, 8'd200};
      4'd7:    c = '{8'd200, 8'd200, 8'd200};
      4'd8:    c = '{8'd100, 8'd100, 8'd100};
      4'd9:    c = '{8'd255, 8'd80, 8'd80};
      4'd10:   c = '{8'd80, 8'd255, 8'd80};
      4'd11:   c = '{8'd255, 8'd255, 8'd80};
      4'd12:   c = '{8'd80, 8'd80, 8'd255};
      4'd13:   c = '{8'd255, 8'd80, 8'd255};
      4'd14:   c = '{8'd80, 8'd255, 8'd255};
      default: c = '{8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cube_level(input logic [2:0] q);
    if (q == 3'd0) return 8'd0;
    return 8'd55 + 8'(q) * 8'd40;
  endfunction

  function automatic rgb_t index_color(input logic [7:0] idx);
    logic [7:0] k;
    logic [7:0] rem;
    logic [2:0] q0;
    logic [2:0] q1;
    logic [2:0] q2;
    logic [7:0] v;
    rgb_t       c;
    k  = idx - 8'd16;
    q0 = 3'd0;
    if (k >= 8'd36)  q0 = 3'd1;
    if (k >= 8'd72)  q0 = 3'd2;
    if (k >= 8'd108) q0 = 3'd3;
    if (k >= 8'd144) q0 = 3'd4;
    if (k >= 8'd180) q0 = 3'd5;
    rem = k - 8'(q0) * 8'd36;
    q1  = 3'd0;
    if (rem >= 8'd6)  q1 = 3'd1;
    if (rem >= 8'd12) q1 = 3'd2;
    if (rem >= 8'd18) q1 = 3'd3;
    if (rem >= 8'd24) q1 = 3'd4;
    if (rem >= 8'd30) q1 = 3'd5;
    q2 = 3'(rem - 8'(q1) * 8'd6);
    v  = 8'd8 + 8'd10 * (idx - 8'd232);
    if (idx < 8'd16) begin
      c = base_color(idx[3:0]);
    end else if (idx < 8'd232) begin
      c = '{cube_level(q0), cube_level(q1), cube_level(q2)};
    end else begin
      c = '{v, v, v};
    end
    return c;
  endfunction

endpackage

// ===== sv/atbp_params.sv =====
// ----------------------------------------------------------------------------
// atbp_params
// CSI number accumulator and parameter list memory with registered read.
// ----------------------------------------------------------------------------
module atbp_params (
  input  logic                     clk,
  input  logic                     rst,
  input  atbp_pkg::plex_t          ctl,
  input  logic [atbp_pkg::PIDX_W-1:0] raddr,
  output atbp_pkg::pinfo_t         info
);
  import atbp_pkg::*;

  logic [PVAL_W-1:0] digit_value;
  logic              digit_seen;
  logic              leader_seen;
  logic [PCNT_W-1:0] param_count;
  logic [PENT_W-1:0] param_list [MAX_PARAMS];
  logic [PENT_W-1:0] rdata;
  logic [PENT_W-1:0] entry;
  logic [19:0]       acc;

  assign entry = digit_seen ? {1'b0, digit_value} : {1'b1, {PVAL_W{1'b0}}};
  assign acc   = ({4'b0, digit_value} << 3) + ({4'b0, digit_value} << 1)
               + {16'b0, ctl.digit_val};

  assign info.count   = param_count;
  assign info.rdata   = rdata;
  assign info.pending = digit_seen | leader_seen;

  always_ff @(posedge clk) begin
    if (ctl.push && param_count < PCNT_W'(MAX_PARAMS)) begin
      param_list[param_count[PIDX_W-1:0]] <= entry;
    end
    rdata <= param_list[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_value <= '0;
      digit_seen  <= 1'b0;
      leader_seen <= 1'b0;
      param_count <= '0;
    end else begin
      if (ctl.push && param_count < PCNT_W'(MAX_PARAMS)) begin
        param_count <= param_count + 1'b1;
      end
      if (ctl.clear_count) begin
        param_count <= '0;
      end
      if (ctl.clear_num) begin
        digit_value <= '0;
        digit_seen  <= 1'b0;
        leader_seen <= 1'b0;
      end else if (ctl.digit) begin
        if (!digit_seen) begin
          digit_value <= {12'b0, ctl.digit_val};
          digit_seen  <= 1'b1;
          leader_seen <= 1'b0;
        end else if (!leader_seen) begin
          digit_value <= (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
        end
      end else if (ctl.leader) begin
        leader_seen <= 1'b1;
      end
    end
  end

endmodule

// ===== sv/ansi_terminal_byte_parser.sv =====
// ----------------------------------------------------------------------------
// ansi_terminal_byte_parser
// VT100/ANSI byte-stream terminal over a single-port-read cell memory.
// ----------------------------------------------------------------------------
// Input words carry either a host byte (mode 0) or a cell read (mode 1).
// Every input word yields exactly one output word: the cell under the
// cursor after the byte, or the addressed cell, plus the cursor position.
// Configuration words set rows/cols in use and clamp the cursor; they are
// taken in any cycle and must only be sent while the block is idle.
// A plain byte or a read goes from accept through execute, memory read and
// read data to the result in the output register. A new word is accepted
// only after the previous one has written the output register.
// Scrolling moves each cell with a read state and a write state and blanks
// the row left over, over all 128 columns of every row in use. Erase line writes one cell per cycle.
// Reset, ESC c and CSI 2J/3J sweep all 8192 cells, one per cycle, with
// input held off. After reset in_ready rises once the sweep is done.
// A stalled receiver holds the result in the output register; one more
// word is accepted and processed, then the block waits for the register.
// ----------------------------------------------------------------------------
module ansi_terminal_byte_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  atbp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output atbp_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  import atbp_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_SCR_RD, S_SCR_WR, S_ERASE, S_CSI_RD0, S_CSI_RD1,
    S_CSI_EX, S_SGR_RD, S_SGR_EX, S_EXT_RD, S_EXT_EX, S_FETCH, S_FWAIT
  } state_t;

  typedef enum logic [1:0] {PM_NORMAL, PM_ESCAPE, PM_CSI, PM_OSC} pmode_t;

  state_t            state;
  pmode_t            pm;
  logic [6:0]        rows_in_use;
  logic [7:0]        cols_in_use;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  pen_t              pen;
  in_word_t          item;
  logic [ADDR_W-1:0] clr_ptr;
  logic              clr_from_item;
  logic [ADDR_W-1:0] scr_ptr;
  logic              scr_down;
  logic [6:0]        scr_cnt;
  logic [COL_W-1:0]  ers_col;
  logic [7:0]        csi_cmd;
  logic [PENT_W-1:0] p0;
  logic [PCNT_W-1:0] sgr_i;
  logic [2:0]        ext_k;
  logic              ext_idx;
  logic              ext_bg;
  logic              read_blank;

  cell_t             cells [NUM_CELLS];
  logic              cell_we;
  logic [ADDR_W-1:0] cell_waddr;
  cell_t             cell_wdata;
  logic [ADDR_W-1:0] cell_raddr;
  cell_t             cell_rdata;

  plex_t             plex;
  pinfo_t            pinfo;
  logic [PIDX_W-1:0] p_raddr;

  logic [6:0]        nrows;
  logic [7:0]        ncols;
  logic [ROW_W-1:0]  last_row;
  logic [COL_W-1:0]  last_col;
  logic [6:0]        cfg_nrows;
  logic [7:0]        cfg_ncols;
  logic [7:0]        b;
  logic              is_digit;
  logic              is_fin;
  logic              is_leader;
  logic              do_print;
  logic [ADDR_W-1:0] fetch_addr;
  logic [ADDR_W-1:0] scr_src;
  logic [ADDR_W-1:0] scr_first;
  logic              scr_copy;
  logic              scr_last;
  logic [7:0]        tab_col;
  logic [PCNT_W:0]   cnt6;
  logic [PCNT_W:0]   sgr_i1;
  logic [PCNT_W:0]   sgr_i2;
  logic [PCNT_W:0]   sgr_i3;
  logic [PCNT_W:0]   sgr_i4;
  logic [PCNT_W:0]   sgr_i5;
  logic [15:0]       p_val;
  logic              p_abs;
  logic [7:0]        p_byte;
  logic [15:0]       n0_d1;
  logic [15:0]       n0_d0;
  logic [15:0]       n1_d1;
  logic [15:0]       h_row;
  logic [15:0]       h_col;
  logic [16:0]       sum_row;
  logic [16:0]       sum_col;
  logic [15:0]       scr_n;
  cell_t             res_cell;

  assign nrows     = clamp_rows(rows_in_use);
  assign ncols     = clamp_cols(cols_in_use);
  assign last_row  = ROW_W'(nrows - 7'd1);
  assign last_col  = COL_W'(ncols - 8'd1);
  assign cfg_nrows = clamp_rows(cfg_data[6:0]);
  assign cfg_ncols = clamp_cols(cfg_data);
  assign b         = item.in_byte;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    is_digit  = b inside {[DIGIT_0:DIGIT_9]};
    is_fin    = b inside {[FINAL_LO:FINAL_HI]};
    is_leader = b inside {BYTE_QMARK, BYTE_GT, BYTE_BANG};
  end

  assign do_print = (state == S_EXEC) && !item.mode && (pm == PM_NORMAL) &&
                    (b >= BYTE_SPACE);
  assign fetch_addr = item.mode ? {item.read_row, item.read_col} : {cur_row, cur_col};

  assign scr_copy  = scr_down ? (scr_ptr[ADDR_W-1:COL_W] != '0)
                              : (scr_ptr[ADDR_W-1:COL_W] < last_row);
  assign scr_src   = scr_down ? scr_ptr - ADDR_W'(MAX_COLS) : scr_ptr + ADDR_W'(MAX_COLS);
  assign scr_first = scr_down ? {last_row, {COL_W{1'b1}}} : '0;
  assign scr_last  = (scr_ptr == (scr_down ? '0 : {last_row, {COL_W{1'b1}}}));
  assign tab_col   = ({1'b0, cur_col} + 8'd8) & 8'hF8;

  assign cnt6   = {1'b0, pinfo.count};
  assign sgr_i1 = {1'b0, sgr_i} + 6'd1;
  assign sgr_i2 = {1'b0, sgr_i} + 6'd2;
  assign sgr_i3 = {1'b0, sgr_i} + 6'd3;
  assign sgr_i4 = {1'b0, sgr_i} + 6'd4;
  assign sgr_i5 = {1'b0, sgr_i} + 6'd5;
  assign p_abs  = pinfo.rdata[PVAL_W];
  assign p_val  = pinfo.rdata[PVAL_W-1:0];
  assign p_byte = p_abs ? 8'hFF : pinfo.rdata[7:0];

  assign n0_d1   = (pinfo.count != '0 && !p0[PVAL_W]) ? p0[PVAL_W-1:0] : 16'd1;
  assign n0_d0   = (pinfo.count != '0 && !p0[PVAL_W]) ? p0[PVAL_W-1:0] : 16'd0;
  assign n1_d1   = (pinfo.count > PCNT_W'(1) && !p_abs) ? p_val : 16'd1;
  assign h_row   = (n0_d1 == 16'd0) ? 16'd0 : n0_d1 - 16'd1;
  assign h_col   = (n1_d1 == 16'd0) ? 16'd0 : n1_d1 - 16'd1;
  assign sum_row = {11'b0, cur_row} + {1'b0, n0_d1};
  assign sum_col = {10'b0, cur_col} + {1'b0, n0_d1};
  assign scr_n   = (n0_d1 > {9'b0, nrows}) ? {9'b0, nrows} : n0_d1;
  assign res_cell = read_blank ? BLANK_CELL : cell_rdata;

  always_comb begin
    plex = '0;
    if (state == S_EXEC && !item.mode) begin
      case (pm)
        PM_NORMAL: plex.clear_num = (b == BYTE_ESC);
        PM_ESCAPE: begin
          plex.clear_num   = (b == BYTE_LBRACK) || (b == BYTE_RBRACK);
          plex.clear_count = (b == BYTE_LBRACK);
        end
        PM_CSI: begin
          if (is_digit) begin
            plex.digit     = 1'b1;
            plex.digit_val = 4'(b - DIGIT_0);
          end else if (b == BYTE_SEMI) begin
            plex.push      = 1'b1;
            plex.clear_num = 1'b1;
          end else if (is_leader) begin
            plex.leader = 1'b1;
          end else if (is_fin) begin
            plex.push = pinfo.pending;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state)
      S_SGR_RD:  p_raddr = sgr_i[PIDX_W-1:0];
      S_EXT_RD:  p_raddr = PIDX_W'({1'b0, sgr_i} + {3'b0, ext_k});
      S_CSI_RD1: p_raddr = PIDX_W'(1);
      default:   p_raddr = '0;
    endcase
  end

  atbp_params u_params (
    .clk   (clk),
    .rst   (rst),
    .ctl   (plex),
    .raddr (p_raddr),
    .info  (pinfo)
  );

  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = scr_ptr;
    cell_wdata = BLANK_CELL;
    cell_raddr = fetch_addr;
    case (state)
      S_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_ptr;
      end
      S_EXEC: begin
        cell_we    = do_print;
        cell_waddr = {cur_row, cur_col};
        cell_wdata = '{ch: b, pen: pen};
      end
      S_SCR_RD: begin
        cell_we    = !scr_copy;
        cell_raddr = scr_src;
      end
      S_SCR_WR: begin
        cell_we    = 1'b1;
        cell_wdata = cell_rdata;
      end
      S_ERASE: begin
        cell_we    = 1'b1;
        cell_waddr = {cur_row, ers_col};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cells[cell_waddr] <= cell_wdata;
    end
    cell_rdata <= cells[cell_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      pm            <= PM_NORMAL;
      rows_in_use   <= 7'd24;
      cols_in_use   <= 8'd80;
      cur_row       <= '0;
      cur_col       <= '0;
      pen           <= DEF_PEN;
      clr_ptr       <= '0;
      clr_from_item <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_ptr <= clr_ptr + 1'b1;
          if (clr_ptr == {ADDR_W{1'b1}}) begin
            state <= clr_from_item ? S_FETCH : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state      <= S_FETCH;
          read_blank <= 1'b0;
          if (item.mode) begin
            read_blank <= ({1'b0, item.read_row} >= nrows) ||
                          ({1'b0, item.read_col} >= ncols);
          end else begin
            case (pm)
              PM_NORMAL: begin
                if (b == BYTE_ESC) begin
                  pm <= PM_ESCAPE;
                end else if (b == BYTE_BS) begin
                  if (cur_col != '0) cur_col <= cur_col - 1'b1;
                end else if (b == BYTE_TAB) begin
                  cur_col <= (tab_col >= ncols) ? last_col : tab_col[COL_W-1:0];
                end else if (b == BYTE_CR) begin
                  cur_col <= '0;
                end else if (b == BYTE_LF ||
                             (do_print && {1'b0, cur_col} + 8'd1 >= ncols)) begin
                  cur_col <= '0;
                  if (cur_row == last_row) begin
                    scr_down <= 1'b0;
                    scr_cnt  <= 7'd1;
                    scr_ptr  <= '0;
                    state    <= S_SCR_RD;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else if (do_print) begin
                  cur_col <= cur_col + 1'b1;
                end
              end
              PM_ESCAPE: begin
                pm <= PM_NORMAL;
                if (b == BYTE_LBRACK) begin
                  pm <= PM_CSI;
                end else if (b == BYTE_RBRACK) begin
                  pm <= PM_OSC;
                end else if (b == BYTE_LPAREN || b == BYTE_RPAREN) begin
                  pm <= PM_ESCAPE;
                end else if (b == ESC_RESET) begin
                  pen           <= DEF_PEN;
                  cur_row       <= '0;
                  cur_col       <= '0;
                  clr_ptr       <= '0;
                  clr_from_item <= 1'b1;
                  state         <= S_CLEAR;
                end else if (b == ESC_INDEX || b == ESC_NEWLINE) begin
                  cur_col <= '0;
                  if (cur_row == last_row) begin
                    scr_down <= 1'b0;
                    scr_cnt  <= 7'd1;
                    scr_ptr  <= '0;
                    state    <= S_SCR_RD;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else if (b == ESC_REVIDX) begin
                  if (cur_row != '0) begin
                    cur_row <= cur_row - 1'b1;
                  end else begin
                    scr_down <= 1'b1;
                    scr_cnt  <= 7'd1;
                    scr_ptr  <= {last_row, {COL_W{1'b1}}};
                    state    <= S_SCR_RD;
                  end
                end
              end
              PM_CSI: begin
                if (is_fin) begin
                  pm      <= PM_NORMAL;
                  csi_cmd <= b;
                  if (b == CSI_SGR) begin
                    sgr_i <= '0;
                    state <= S_SGR_RD;
                  end else if (b == CSI_ERASE_L) begin
                    ers_col <= cur_col;
                    state   <= S_ERASE;
                  end else begin
                    state <= S_CSI_RD0;
                  end
                end else if (!is_digit && !is_leader && b != BYTE_SEMI) begin
                  pm <= PM_NORMAL;
                end
              end
              default: begin
                if (b == BYTE_BEL || b == BYTE_BSLASH) pm <= PM_NORMAL;
              end
            endcase
          end
        end
        S_SCR_RD, S_SCR_WR: begin
          if (state == S_SCR_RD && scr_copy) begin
            state <= S_SCR_WR;
          end else if (scr_last) begin
            if (scr_cnt == 7'd1) begin
              state <= S_FETCH;
            end else begin
              scr_cnt <= scr_cnt - 1'b1;
              scr_ptr <= scr_first;
              state   <= S_SCR_RD;
            end
          end else begin
            scr_ptr <= scr_down ? scr_ptr - 1'b1 : scr_ptr + 1'b1;
            state   <= S_SCR_RD;
          end
        end
        S_ERASE: begin
          ers_col <= ers_col + 1'b1;
          if ({1'b0, ers_col} + 8'd1 >= ncols) state <= S_FETCH;
        end
        S_CSI_RD0: state <= S_CSI_RD1;
        S_CSI_RD1: begin
          p0    <= pinfo.rdata;
          state <= S_CSI_EX;
        end
        S_CSI_EX: begin
          state <= S_FETCH;
          case (csi_cmd)
            CSI_UP: begin
              cur_row <= (n0_d1 >= {10'b0, cur_row}) ? '0 : cur_row - ROW_W'(n0_d1);
            end
            CSI_DOWN: begin
              cur_row <= (sum_row > {11'b0, last_row}) ? last_row : sum_row[ROW_W-1:0];
            end
            CSI_FWD: begin
              cur_col <= (sum_col > {10'b0, last_col}) ? last_col : sum_col[COL_W-1:0];
            end
            CSI_BACK: begin
              cur_col <= (n0_d1 >= {9'b0, cur_col}) ? '0 : cur_col - COL_W'(n0_d1);
            end
            CSI_POS, CSI_POS_F: begin
              cur_row <= (h_row > {10'b0, last_row}) ? last_row : h_row[ROW_W-1:0];
              cur_col <= (h_col > {9'b0, last_col}) ? last_col : h_col[COL_W-1:0];
            end
            CSI_ERASE: begin
              if (n0_d0 == 16'd2 || n0_d0 == 16'd3) begin
                cur_row       <= '0;
                cur_col       <= '0;
                clr_ptr       <= '0;
                clr_from_item <= 1'b1;
                state         <= S_CLEAR;
              end
            end
            CSI_SCROLL: begin
              if (scr_n != 16'd0) begin
                scr_down <= 1'b0;
                scr_cnt  <= scr_n[6:0];
                scr_ptr  <= '0;
                state    <= S_SCR_RD;
              end
            end
            default: ;
          endcase
        end
        S_SGR_RD: begin
          if (pinfo.count == '0) begin
            pen   <= DEF_PEN;
            state <= S_FETCH;
          end else begin
            state <= S_SGR_EX;
          end
        end
        S_SGR_EX: begin
          if (!p_abs && (p_val == SGR_FG_EXT || p_val == SGR_BG_EXT) && sgr_i1 < cnt6) begin
            ext_bg <= (p_val == SGR_BG_EXT);
            ext_k  <= 3'd1;
            state  <= S_EXT_RD;
          end else begin
            if (!p_abs) begin
              case (p_val) inside
                SGR_RESET:          pen <= DEF_PEN;
                SGR_BOLD:           pen.flags <= pen.flags | FL_BOLD;
                SGR_ITALIC:         pen.flags <= pen.flags | FL_ITALIC;
                SGR_UNDER:          pen.flags <= pen.flags | FL_UNDER;
                SGR_REVERSE:        pen.flags <= pen.flags | FL_REVERSE;
                SGR_NO_BOLD:        pen.flags <= pen.flags & ~FL_BOLD;
                SGR_NO_ITALIC:      pen.flags <= pen.flags & ~FL_ITALIC;
                SGR_NO_UNDER:       pen.flags <= pen.flags & ~FL_UNDER;
                SGR_NO_REV:         pen.flags <= pen.flags & ~FL_REVERSE;
                SGR_FG_DEF:         pen.fg <= DEF_FG;
                SGR_BG_DEF:         pen.bg <= DEF_BG;
                [SGR_FG_LO:SGR_FG_HI]:   pen.fg <= base_color(4'(p_val - SGR_FG_LO));
                [SGR_BG_LO:SGR_BG_HI]:   pen.bg <= base_color(4'(p_val - SGR_BG_LO));
                [SGR_FGB_LO:SGR_FGB_HI]: pen.fg <= base_color(4'(p_val - 16'd82));
                [SGR_BGB_LO:SGR_BGB_HI]: pen.bg <= base_color(4'(p_val - 16'd92));
                default: ;
              endcase
            end
            sgr_i <= PCNT_W'(sgr_i1);
            state <= (sgr_i1 >= cnt6) ? S_FETCH : S_SGR_RD;
          end
        end
        S_EXT_RD: state <= S_EXT_EX;
        S_EXT_EX: begin
          if (ext_k == 3'd1) begin
            if (pinfo.rdata == EXT_RGB && sgr_i4 < cnt6) begin
              ext_idx <= 1'b0;
              ext_k   <= 3'd2;
              state   <= S_EXT_RD;
            end else if (pinfo.rdata == EXT_INDEX && sgr_i2 < cnt6) begin
              ext_idx <= 1'b1;
              ext_k   <= 3'd2;
              state   <= S_EXT_RD;
            end else begin
              sgr_i <= PCNT_W'(sgr_i1);
              state <= (sgr_i1 >= cnt6) ? S_FETCH : S_SGR_RD;
            end
          end else if (ext_idx) begin
            if (ext_bg) pen.bg <= index_color(p_byte);
            else        pen.fg <= index_color(p_byte);
            sgr_i <= PCNT_W'(sgr_i3);
            state <= (sgr_i3 >= cnt6) ? S_FETCH : S_SGR_RD;
          end else begin
            case (ext_k)
              3'd2: if (ext_bg) pen.bg.r <= p_byte; else pen.fg.r <= p_byte;
              3'd3: if (ext_bg) pen.bg.g <= p_byte; else pen.fg.g <= p_byte;
              default: if (ext_bg) pen.bg.b <= p_byte; else pen.fg.b <= p_byte;
            endcase
            if (ext_k == 3'd4) begin
              sgr_i <= PCNT_W'(sgr_i5);
              state <= (sgr_i5 >= cnt6) ? S_FETCH : S_SGR_RD;
            end else begin
              ext_k <= ext_k + 1'b1;
              state <= S_EXT_RD;
            end
          end
        end
        S_FETCH: state <= S_FWAIT;
        S_FWAIT: begin
          if (!out_valid || out_ready) begin
            out_valid           <= 1'b1;
            out_data.cell_char  <= res_cell.ch;
            out_data.fg_red     <= res_cell.pen.fg.r;
            out_data.fg_green   <= res_cell.pen.fg.g;
            out_data.fg_blue    <= res_cell.pen.fg.b;
            out_data.bg_red     <= res_cell.pen.bg.r;
            out_data.bg_green   <= res_cell.pen.bg.g;
            out_data.bg_blue    <= res_cell.pen.bg.b;
            out_data.cell_flags <= res_cell.pen.flags;
            out_data.cursor_row <= cur_row;
            out_data.cursor_col <= cur_col;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_valid) begin
        if (cfg_index == REG_ROWS) begin
          rows_in_use <= cfg_data[6:0];
          if ({1'b0, cur_row} >= cfg_nrows) cur_row <= ROW_W'(cfg_nrows - 7'd1);
        end else if (cfg_index == REG_COLS) begin
          cols_in_use <= cfg_data;
          if ({1'b0, cur_col} >= cfg_ncols) cur_col <= COL_W'(cfg_ncols - 8'd1);
        end
      end
    end
  end

endmodule
